FILE: hdl/ssm_pkg.sv
// shared constants, codes and interface types of the sorted set merge core
`default_nettype none
package ssm_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int RESULT_CAP   = 32;
   localparam int WORK_DEPTH   = 2 * MAX_ELEMENTS;
   localparam int VALUE_W      = 32;
   localparam int CW           = $clog2(MAX_ELEMENTS + 1);
   localparam int AW           = (WORK_DEPTH > 2) ? $clog2(WORK_DEPTH) : 1;
   localparam int RAM_DEPTH    = 1 << AW;
   localparam int NMAX         = (RESULT_CAP > WORK_DEPTH) ? RESULT_CAP : WORK_DEPTH;
   localparam int NW           = $clog2(NMAX + 1);

   localparam logic [2:0] OP_UNION = 3'd0;
   localparam logic [2:0] OP_INTER = 3'd1;
   localparam logic [2:0] OP_A_B   = 3'd2;
   localparam logic [2:0] OP_SYM   = 3'd3;
   localparam logic [2:0] OP_B_A   = 3'd4;

   localparam logic [1:0] MODE_LOAD_A = 2'd0;
   localparam logic [1:0] MODE_LOAD_B = 2'd1;
   localparam logic [1:0] MODE_RUN    = 2'd2;

   typedef struct packed {
      logic               we;
      logic [AW-1:0]      waddr;
      logic [VALUE_W-1:0] wdata;
      logic [AW-1:0]      raddr;
   } ram_req_type;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               empty;
      logic               overflowed;
   } push_type;

endpackage
`default_nettype wire

FILE: hdl/sorted_set_merge_operations_core.sv
// top level of the sorted set merge core: csr, list memories, engine, output
//
// Requests with mode 0 or 1 append one value to list A or B and are taken one
// per cycle; a full list drops the value and sets the sticky overflow flag.
// A run request merge-walks both lists, one step per cycle unless the output
// register is full, where a step emits or skips list heads; each list memory
// has one read port, so one head of each list is fetched per cycle. Symmetric
// difference makes three walks: A minus B and B minus A into the upper
// halves of the list memories, then their union. Each result is held in a
// pending register until the next is emitted, so that the final one can
// carry last; an empty result gives a single response with empty_res set.
// Requests are stalled from a run until its final response sits in the
// output register. Both lists are empty after a run. The user must write
// the operation register only while no run is in flight; it is not enforced.
`default_nettype none
module sorted_set_merge_operations_core
   import ssm_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_mode,
   input  wire logic signed [VALUE_W-1:0]   req_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [VALUE_W-1:0]        rsp_result_value,
   output logic                             rsp_last,
   output logic                             rsp_empty_res,
   output logic                             rsp_overflowed,
   input  wire logic                        csr_wr_en,
   input  wire logic [2:0]                  csr_wr_data
);

   logic [2:0]         operation_ff, operation_in;
   ram_req_type        ram_a, ram_b;
   logic [VALUE_W-1:0] rd_a, rd_b;
   push_type           push;
   logic               out_free;

   always_comb begin
      operation_in = operation_ff;
      if (csr_wr_en) begin
         operation_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff <= OP_UNION;
      end else begin
         operation_ff <= operation_in;
      end
   end

   ssm_list_ram u_ram_a (
      .clock   (clock),
      .ram_req (ram_a),
      .rd_data (rd_a)
   );

   ssm_list_ram u_ram_b (
      .clock   (clock),
      .ram_req (ram_b),
      .rd_data (rd_b)
   );

   ssm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_value (req_value),
      .operation (operation_ff),
      .ram_a     (ram_a),
      .ram_b     (ram_b),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .push      (push),
      .out_free  (out_free)
   );

   ssm_out_stage u_out (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_overflowed   (rsp_overflowed)
   );

   // an empty result is always the final one
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last)
      else $error("empty response without last");

   // a run holds off further requests
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_RUN |=> req_stall)
      else $error("request taken during a run");

   // loads never make the block busy
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == MODE_LOAD_A || req_mode == MODE_LOAD_B)
      |=> !req_stall)
      else $error("stall after a load");

   // a response only appears after a run started
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a run");

endmodule
`default_nettype wire

FILE: hdl/ssm_list_ram.sv
// list memory: one write port, one registered read port
`default_nettype none
module ssm_list_ram
   import ssm_pkg::*;
(
   input  wire logic               clock,
   input  wire ram_req_type        ram_req,
   output logic [VALUE_W-1:0]      rd_data
);

   logic [VALUE_W-1:0] mem_ff [RAM_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem_ff[ram_req.waddr] <= ram_req.wdata;
      end
      rd_data_ff <= mem_ff[ram_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/ssm_out_stage.sv
// response output register between the merge engine and the response channel
`default_nettype none
module ssm_out_stage
   import ssm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire push_type             push,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_result_value,
   output logic                      rsp_last,
   output logic                      rsp_empty_res,
   output logic                      rsp_overflowed
);

   logic               valid_ff, valid_in;
   logic [VALUE_W-1:0] value_ff;
   logic               last_ff;
   logic               empty_ff;
   logic               ovf_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (push.valid) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         value_ff <= push.value;
         last_ff  <= push.last;
         empty_ff <= push.empty;
         ovf_ff   <= push.overflowed;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_value = value_ff;
   assign rsp_last         = last_ff;
   assign rsp_empty_res    = empty_ff;
   assign rsp_overflowed   = ovf_ff;

endmodule
`default_nettype wire

FILE: hdl/ssm_engine.sv
// list loading, merge walk sequencer and held result for the last flag
`default_nettype none
module ssm_engine
   import ssm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_mode,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic [2:0]         operation,
   output ram_req_type             ram_a,
   output ram_req_type             ram_b,
   input  wire logic [VALUE_W-1:0] rd_a,
   input  wire logic [VALUE_W-1:0] rd_b,
   output push_type                push,
   input  wire logic               out_free
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_WALK  = 3'b010,
      S_FLUSH = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      K_UNION = 2'd0,
      K_INTER = 2'd1,
      K_MINUS = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      P_ONLY  = 4'b0001,
      P_D1    = 4'b0010,
      P_D2    = 4'b0100,
      P_MERGE = 4'b1000
   } phase_type;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   phase_type          phase_ff, phase_in;
   logic               swap_ff, swap_in;
   logic               base_ff, base_in;
   logic               sink_out_ff, sink_out_in;
   logic [CW-1:0]      len_x_ff, len_x_in;
   logic [CW-1:0]      len_y_ff, len_y_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [CW-1:0]      nd1_ff, nd1_in;
   logic [CW-1:0]      cnt_a_ff, cnt_a_in;
   logic [CW-1:0]      cnt_b_ff, cnt_b_in;
   logic               ovf_ff, ovf_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [VALUE_W-1:0] pend_ff, pend_in;

   logic               accept;
   logic [VALUE_W-1:0] hx, hy;
   logic               x_ok, y_ok, lt, eq;
   logic               emit, adv_i, adv_j, done, blocked;
   logic [VALUE_W-1:0] emit_val;
   logic [AW-1:0]      base_addr, wr_addr, addr_x, addr_y;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign hx = swap_ff ? rd_b : rd_a;
   assign hy = swap_ff ? rd_a : rd_b;

   // one merge step from the current heads
   always_comb begin
      x_ok     = (i_ff < len_x_ff);
      y_ok     = (j_ff < len_y_ff);
      lt       = ($signed(hx) < $signed(hy));
      eq       = (hx == hy);
      emit     = 1'b0;
      emit_val = hx;
      adv_i    = 1'b0;
      adv_j    = 1'b0;
      done     = 1'b0;
      if (x_ok && y_ok) begin
         unique case (kind_ff)
            K_UNION: begin
               emit = 1'b1;
               if (lt) begin
                  adv_i = 1'b1;
               end else if (eq) begin
                  adv_i = 1'b1;
                  adv_j = 1'b1;
               end else begin
                  emit_val = hy;
                  adv_j    = 1'b1;
               end
            end
            K_INTER: begin
               if (eq) begin
                  emit  = 1'b1;
                  adv_i = 1'b1;
                  adv_j = 1'b1;
               end else if (lt) begin
                  adv_i = 1'b1;
               end else begin
                  adv_j = 1'b1;
               end
            end
            K_MINUS: begin
               if (lt) begin
                  emit  = 1'b1;
                  adv_i = 1'b1;
               end else if (eq) begin
                  adv_i = 1'b1;
                  adv_j = 1'b1;
               end else begin
                  adv_j = 1'b1;
               end
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end else if (x_ok && kind_ff != K_INTER) begin
         emit  = 1'b1;
         adv_i = 1'b1;
      end else if (y_ok && kind_ff == K_UNION) begin
         emit     = 1'b1;
         emit_val = hy;
         adv_j    = 1'b1;
      end else begin
         done = 1'b1;
      end
      // result cap reached
      if (sink_out_ff && n_ff == NW'(RESULT_CAP)) begin
         emit  = 1'b0;
         adv_i = 1'b0;
         adv_j = 1'b0;
         done  = 1'b1;
      end
      blocked = emit && sink_out_ff && pend_valid_ff && !out_free;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      phase_in      = phase_ff;
      swap_in       = swap_ff;
      base_in       = base_ff;
      sink_out_in   = sink_out_ff;
      len_x_in      = len_x_ff;
      len_y_in      = len_y_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      nd1_in        = nd1_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      ovf_in        = ovf_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      ram_a         = '0;
      ram_b         = '0;
      push          = '0;
      push.overflowed = ovf_ff;
      wr_addr       = AW'(MAX_ELEMENTS) + AW'(n_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority case (req_mode)
                  MODE_LOAD_A: begin
                     if (cnt_a_ff < CW'(MAX_ELEMENTS)) begin
                        ram_a.we    = 1'b1;
                        ram_a.waddr = AW'(cnt_a_ff);
                        ram_a.wdata = req_value;
                        cnt_a_in    = cnt_a_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  MODE_LOAD_B: begin
                     if (cnt_b_ff < CW'(MAX_ELEMENTS)) begin
                        ram_b.we    = 1'b1;
                        ram_b.waddr = AW'(cnt_b_ff);
                        ram_b.wdata = req_value;
                        cnt_b_in    = cnt_b_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  MODE_RUN: begin
                     i_in        = '0;
                     j_in        = '0;
                     n_in        = '0;
                     base_in     = 1'b0;
                     sink_out_in = 1'b1;
                     swap_in     = 1'b0;
                     len_x_in    = cnt_a_ff;
                     len_y_in    = cnt_b_ff;
                     phase_in    = P_ONLY;
                     state_in    = S_WALK;
                     priority case (operation)
                        OP_UNION: kind_in = K_UNION;
                        OP_INTER: kind_in = K_INTER;
                        OP_A_B:   kind_in = K_MINUS;
                        OP_SYM: begin
                           kind_in     = K_MINUS;
                           phase_in    = P_D1;
                           sink_out_in = 1'b0;
                        end
                        OP_B_A: begin
                           kind_in  = K_MINUS;
                           swap_in  = 1'b1;
                           len_x_in = cnt_b_ff;
                           len_y_in = cnt_a_ff;
                        end
                        default: state_in = S_FLUSH;
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (done) begin
               i_in = '0;
               j_in = '0;
               n_in = '0;
               priority case (phase_ff)
                  P_D1: begin
                     phase_in = P_D2;
                     swap_in  = 1'b1;
                     len_x_in = cnt_b_ff;
                     len_y_in = cnt_a_ff;
                     nd1_in   = CW'(n_ff);
                  end
                  P_D2: begin
                     phase_in    = P_MERGE;
                     kind_in     = K_UNION;
                     swap_in     = 1'b0;
                     base_in     = 1'b1;
                     sink_out_in = 1'b1;
                     len_x_in    = nd1_ff;
                     len_y_in    = CW'(n_ff);
                  end
                  default: begin
                     n_in     = n_ff;
                     state_in = S_FLUSH;
                  end
               endcase
            end else if (!blocked) begin
               i_in = i_ff + CW'(adv_i);
               j_in = j_ff + CW'(adv_j);
               if (emit) begin
                  n_in = n_ff + 1'b1;
                  if (sink_out_ff) begin
                     if (pend_valid_ff) begin
                        push.valid = 1'b1;
                        push.value = pend_ff;
                     end
                     pend_valid_in = 1'b1;
                     pend_in       = emit_val;
                  end else if (swap_ff) begin
                     ram_b.we    = 1'b1;
                     ram_b.waddr = wr_addr;
                     ram_b.wdata = emit_val;
                  end else begin
                     ram_a.we    = 1'b1;
                     ram_a.waddr = wr_addr;
                     ram_a.wdata = emit_val;
                  end
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               push.valid    = 1'b1;
               push.last     = 1'b1;
               push.empty    = !pend_valid_ff;
               push.value    = pend_valid_ff ? pend_ff : '0;
               pend_valid_in = 1'b0;
               cnt_a_in      = '0;
               cnt_b_in      = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // heads for the next cycle are read at the next indexes
      base_addr   = base_in ? AW'(MAX_ELEMENTS) : '0;
      addr_x      = base_addr + AW'(i_in);
      addr_y      = base_addr + AW'(j_in);
      ram_a.raddr = swap_in ? addr_y : addr_x;
      ram_b.raddr = swap_in ? addr_x : addr_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         phase_ff      <= P_ONLY;
         kind_ff       <= K_UNION;
         swap_ff       <= 1'b0;
         base_ff       <= 1'b0;
         sink_out_ff   <= 1'b1;
         i_ff          <= '0;
         j_ff          <= '0;
         n_ff          <= '0;
         len_x_ff      <= '0;
         len_y_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         swap_ff       <= swap_in;
         base_ff       <= base_in;
         sink_out_ff   <= sink_out_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         n_ff          <= n_in;
         len_x_ff      <= len_x_in;
         len_y_ff      <= len_y_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      nd1_ff  <= nd1_in;
   end

endmodule
`default_nettype wire

FILE: bench/tb.sv
// self-checking bench for the sorted set merge core with its own set-operation predictor
`default_nettype none
module tb;
   import ssm_pkg::*;

   typedef logic signed [VALUE_W-1:0] elem_type;
   typedef elem_type elem_q_type[$];

   typedef struct {
      elem_type value;
      logic     last;
      logic     empty;
      logic     overflowed;
   } result_type;

   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam int RANDOM_REQUESTS = 270;
   localparam int QUIET_CYCLES    = 3 * WORK_DEPTH + 8;
   localparam int HANG_LIMIT      = 4000;
   localparam elem_type VALUE_MIN = 32'sh8000_0000;
   localparam elem_type VALUE_MAX = 32'sh7fff_ffff;

   class set_merge_scoreboard;
      elem_type    list_a[$];
      elem_type    list_b[$];
      logic        overflow;
      logic [2:0]  operation;
      result_type  pending[$];
      int          errors;
      int          checked;
      int          runs;

      function new();
         overflow  = 1'b0;
         operation = OP_UNION;
         errors    = 0;
         checked   = 0;
         runs      = 0;
      endfunction

      function void set_operation(logic [2:0] op);
         operation = op;
      endfunction

      function elem_q_type merge_union(elem_q_type x, elem_q_type y);
         elem_q_type o;
         int i;
         int j;
         i = 0;
         j = 0;
         while (i < x.size() && j < y.size()) begin
            if (x[i] < y[j]) begin
               o.push_back(x[i]);
               i++;
            end else if (x[i] == y[j]) begin
               o.push_back(x[i]);
               i++;
               j++;
            end else begin
               o.push_back(y[j]);
               j++;
            end
         end
         while (i < x.size()) begin
            o.push_back(x[i]);
            i++;
         end
         while (j < y.size()) begin
            o.push_back(y[j]);
            j++;
         end
         return o;
      endfunction

      function elem_q_type merge_common(elem_q_type x, elem_q_type y);
         elem_q_type o;
         int i;
         int j;
         i = 0;
         j = 0;
         while (i < x.size() && j < y.size()) begin
            if (x[i] == y[j]) begin
               o.push_back(x[i]);
               i++;
               j++;
            end else if (x[i] < y[j]) begin
               i++;
            end else begin
               j++;
            end
         end
         return o;
      endfunction

      function elem_q_type merge_minus(elem_q_type x, elem_q_type y);
         elem_q_type o;
         int i;
         int j;
         i = 0;
         j = 0;
         while (i < x.size() && j < y.size()) begin
            if (x[i] < y[j]) begin
               o.push_back(x[i]);
               i++;
            end else if (x[i] == y[j]) begin
               i++;
               j++;
            end else begin
               j++;
            end
         end
         while (i < x.size()) begin
            o.push_back(x[i]);
            i++;
         end
         return o;
      endfunction

      function void predict_run();
         elem_q_type merged;
         result_type r;
         int total;
         case (operation)
            OP_UNION: merged = merge_union(list_a, list_b);
            OP_INTER: merged = merge_common(list_a, list_b);
            OP_A_B:   merged = merge_minus(list_a, list_b);
            OP_SYM:   merged = merge_union(merge_minus(list_a, list_b),
                                           merge_minus(list_b, list_a));
            OP_B_A:   merged = merge_minus(list_b, list_a);
            default:  merged.delete();
         endcase
         list_a.delete();
         list_b.delete();
         runs++;
         r.overflowed = overflow;
         if (merged.size() == 0) begin
            r.value = '0;
            r.last  = 1'b1;
            r.empty = 1'b1;
            pending.push_back(r);
            return;
         end
         total = (merged.size() > RESULT_CAP) ? RESULT_CAP : merged.size();
         for (int k = 0; k < total; k++) begin
            r.value = merged[k];
            r.last  = (k == total - 1);
            r.empty = 1'b0;
            pending.push_back(r);
         end
      endfunction

      function void note_request(logic [1:0] mode, elem_type value);
         case (mode)
            MODE_LOAD_A: begin
               if (list_a.size() < MAX_ELEMENTS) list_a.push_back(value);
               else overflow = 1'b1;
            end
            MODE_LOAD_B: begin
               if (list_b.size() < MAX_ELEMENTS) list_b.push_back(value);
               else overflow = 1'b1;
            end
            MODE_RUN: predict_run();
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(elem_type value, logic last, logic empty, logic overflowed);
         result_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response value %0d last %b empty %b ovf %b",
                             value, last, empty, overflowed));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (value !== want.value || last !== want.last || empty !== want.empty ||
             overflowed !== want.overflowed)
            report($sformatf("got value %0d last %b empty %b ovf %b, want %0d %b %b %b",
                             value, last, empty, overflowed, want.value, want.last,
                             want.empty, want.overflowed));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   elem_type    req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   elem_type    rsp_result_value;
   logic        rsp_last;
   logic        rsp_empty_res;
   logic        rsp_overflowed;
   logic        csr_wr_en;
   logic [2:0]  csr_wr_data;

   set_merge_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int requests;
   int quiet_cycles;

   sorted_set_merge_operations_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_overflowed   (rsp_overflowed),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_result_value, rsp_last, rsp_empty_res, rsp_overflowed);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("no handshake for %0d cycles", HANG_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // entered and left at a falling edge
   task send_request(input logic [1:0] mode, input elem_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode  = mode;
      req_value = value;
      do @(posedge clock); while (req_stall);
      sb.note_request(mode, value);
      if (mode != MODE_UNUSED) requests++;
      @(negedge clock);
   endtask

   task wait_quiet();
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task write_operation(input logic [2:0] op);
      wait_quiet();
      csr_wr_en   = 1'b1;
      csr_wr_data = op;
      @(posedge clock);
      sb.set_operation(op);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // two lists drawn from one ascending pool so that they share values
   task run_set(input int na, input int nb, input bit scrambled);
      elem_type a_vals[$];
      elem_type b_vals[$];
      elem_type tmp;
      longint   cur;
      int       pick;
      int       ia;
      int       ib;
      int       j;
      case ($urandom_range(9))
         0: cur = -64'sd2147483648;
         1: cur = 64'sd2147483447;
         default: begin
            cur = longint'($signed($urandom));
            if (cur > 64'sd2147483447) cur = 64'sd2147483447;
         end
      endcase
      while (a_vals.size() < na || b_vals.size() < nb) begin
         if ($urandom_range(9) != 0) cur += $urandom_range(1, 3);
         pick = $urandom_range(2);
         if (a_vals.size() >= na) pick = 1;
         else if (b_vals.size() >= nb) pick = 0;
         if (pick != 1) a_vals.push_back(elem_type'(cur));
         if (pick != 0) b_vals.push_back(elem_type'(cur));
      end
      if (scrambled) begin
         for (int i = 0; i < a_vals.size(); i++) begin
            j = $urandom_range(a_vals.size() - 1);
            tmp = a_vals[i];
            a_vals[i] = a_vals[j];
            a_vals[j] = tmp;
         end
         for (int i = 0; i < b_vals.size(); i++) begin
            j = $urandom_range(b_vals.size() - 1);
            tmp = b_vals[i];
            b_vals[i] = b_vals[j];
            b_vals[j] = tmp;
         end
      end
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
         if ($urandom_range(11) == 0) send_request(MODE_UNUSED, $urandom);
         if (ib >= nb || (ia < na && $urandom_range(1) == 1)) begin
            send_request(MODE_LOAD_A, a_vals[ia]);
            ia++;
         end else begin
            send_request(MODE_LOAD_B, b_vals[ib]);
            ib++;
         end
      end
      send_request(MODE_RUN, $urandom);
   endtask

   function int list_size();
      return ($urandom_range(11) == 0) ? MAX_ELEMENTS : $urandom_range(0, 6);
   endfunction

   task set_idling(input int phase);
      case (phase)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
         default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
   endtask

   initial begin
      int start;
      int g;
      sb             = new();
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_LOAD_A;
      req_value      = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = OP_UNION;
      rsp_stall      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      requests       = 0;
      quiet_cycles   = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, each operation, empty result, unused codes
      write_operation(OP_UNION);
      send_request(MODE_LOAD_A, VALUE_MIN);
      send_request(MODE_LOAD_B, VALUE_MAX);
      send_request(MODE_RUN, '0);
      send_request(MODE_RUN, '1);
      write_operation(OP_INTER);
      send_request(MODE_LOAD_A, 0);
      send_request(MODE_LOAD_A, 5);
      send_request(MODE_LOAD_B, 0);
      send_request(MODE_LOAD_B, 7);
      send_request(MODE_RUN, '0);
      write_operation(OP_A_B);
      send_request(MODE_LOAD_A, 1);
      send_request(MODE_LOAD_A, 2);
      send_request(MODE_LOAD_A, 3);
      send_request(MODE_LOAD_B, 2);
      send_request(MODE_RUN, '0);
      write_operation(OP_B_A);
      send_request(MODE_LOAD_A, 4);
      send_request(MODE_LOAD_B, -4);
      send_request(MODE_LOAD_B, 4);
      send_request(MODE_LOAD_B, 9);
      send_request(MODE_RUN, '0);
      write_operation(OP_SYM);
      send_request(MODE_LOAD_A, 1);
      send_request(MODE_LOAD_A, 3);
      send_request(MODE_UNUSED, '1);
      send_request(MODE_LOAD_B, 3);
      send_request(MODE_LOAD_B, 5);
      send_request(MODE_RUN, '0);
      write_operation(OP_UNUSED_HI);
      send_request(MODE_LOAD_A, 1);
      send_request(MODE_RUN, '0);

      start = requests;
      g = 0;
      while (requests - start < RANDOM_REQUESTS) begin
         write_operation(3'(g % 8));
         set_idling((g / 3) % 4);
         repeat (2) run_set(list_size(), list_size(), $urandom_range(9) == 0);
         g++;
      end

      // full lists last, as the overflow flag stays set until reset
      set_idling(3);
      write_operation(OP_UNION);
      run_set(MAX_ELEMENTS + 1, 2, 1'b0);
      write_operation(OP_SYM);
      run_set(MAX_ELEMENTS, MAX_ELEMENTS + 2, 1'b0);

      wait_quiet();
      $display("%0d requests and %0d runs, %0d responses checked", requests, sb.runs,
               sb.checked);
      $display("all eight operation codes, full lists and four idle patterns exercised");
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
hdl/ssm_pkg.sv
hdl/ssm_list_ram.sv
hdl/ssm_out_stage.sv
hdl/ssm_engine.sv
hdl/sorted_set_merge_operations_core.sv
bench/tb.sv
